// ===== hdl/gisc_pkg.sv =====
package gisc_pkg;

    // Largest graph the stores hold
    localparam int MAX_VERTICES = 64;
    localparam int VIDX_W       = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;

    // Fixed field widths
    localparam int IDX_W   = 6;
    localparam int ROW_W   = 64;
    localparam int COLOR_W = 6;
    localparam int CFG_W   = 7;

    localparam logic [CFG_W-1:0] VCOUNT_RESET = 7'd64;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SCAN_RD,
        ST_SCAN_EV,
        ST_EMIT_RD,
        ST_EMIT_OUT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic in_ready;
        logic start_scan;
        logic eval;
        logic emit_load;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic last_accept;
        logic vtx_last;
        logic all_colored;
        logic out_free;
    } t_status;

endpackage

// ===== hdl/gisc_in_if.sv =====
interface gisc_in_if;
    logic                          valid;
    logic                          ready;
    logic [gisc_pkg::IDX_W-1:0]    vertex_index;
    logic [gisc_pkg::ROW_W-1:0]    adjacency_row;
    logic                          last_row;

    modport source (output valid, vertex_index, adjacency_row, last_row, input ready);
    modport sink   (input valid, vertex_index, adjacency_row, last_row, output ready);
endinterface

// ===== hdl/gisc_out_if.sv =====
interface gisc_out_if;
    logic                          valid;
    logic                          ready;
    logic [gisc_pkg::IDX_W-1:0]    result_vertex;
    logic [gisc_pkg::COLOR_W-1:0]  vertex_color;
    logic                          last_result;

    modport source (output valid, result_vertex, vertex_color, last_result, input ready);
    modport sink   (input valid, result_vertex, vertex_color, last_result, output ready);
endinterface

// ===== hdl/gisc_ctrl.sv =====
module gisc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  gisc_pkg::t_status i_status,
    output gisc_pkg::t_cmd    o_cmd
);
    import gisc_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_LOAD: begin
                if (i_status.last_accept) begin
                    n_state = ST_SCAN_RD;
                end
            end
            ST_SCAN_RD: begin
                n_state = ST_SCAN_EV;
            end
            ST_SCAN_EV: begin
                if (i_status.vtx_last && i_status.all_colored) begin
                    n_state = ST_EMIT_RD;
                end else begin
                    n_state = ST_SCAN_RD;
                end
            end
            ST_EMIT_RD: begin
                n_state = ST_EMIT_OUT;
            end
            ST_EMIT_OUT: begin
                if (i_status.out_free) begin
                    n_state = i_status.vtx_last ? ST_LOAD : ST_EMIT_RD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    // Commands
    always_comb begin
        o_cmd = '0;
        case (r_state)
            ST_LOAD: begin
                o_cmd.in_ready   = 1'b1;
                o_cmd.start_scan = i_status.last_accept;
            end
            ST_SCAN_EV: begin
                o_cmd.eval = 1'b1;
            end
            ST_EMIT_OUT: begin
                o_cmd.emit_load = i_status.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// ===== hdl/gisc_datapath.sv =====
module gisc_datapath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [gisc_pkg::CFG_W-1:0]   i_cfg_wr_data,
    gisc_in_if.sink                      i_in,
    gisc_out_if.source                   o_out,
    input  gisc_pkg::t_cmd               i_cmd,
    output gisc_pkg::t_status            o_status
);
    import gisc_pkg::*;

    // Stores
    logic [ROW_W-1:0]   r_adj_mem   [MAX_VERTICES];
    logic [COLOR_W-1:0] r_color_mem [MAX_VERTICES];
    logic [ROW_W-1:0]   r_adj_rd;
    logic [COLOR_W-1:0] r_color_rd;

    logic [CFG_W-1:0]        r_vcount;
    logic [VIDX_W-1:0]       r_vtx, n_vtx;
    logic [MAX_VERTICES-1:0] r_colored, n_colored;
    logic [MAX_VERTICES-1:0] r_sel, n_sel;
    logic [MAX_VERTICES-1:0] r_excl, n_excl;
    logic [COLOR_W-1:0]      r_round, n_round;

    logic                    r_out_valid;
    logic [IDX_W-1:0]        r_out_vertex;
    logic [COLOR_W-1:0]      r_out_color;
    logic                    r_out_last;

    logic [CFG_W-1:0]        s_n;
    logic [VIDX_W-1:0]       s_last_idx;
    logic [MAX_VERTICES-1:0] s_in_use;
    logic [MAX_VERTICES-1:0] s_vbit;
    logic [MAX_VERTICES-1:0] s_row;
    logic [MAX_VERTICES-1:0] s_colored_after;
    logic                    s_take;
    logic                    s_acc;
    logic                    s_wr_ok;
    logic                    s_vtx_last;
    logic                    s_out_free;

    // Saturated vertex count and in-use mask
    always_comb begin
        if (r_vcount == '0) begin
            s_n = CFG_W'(1);
        end else if (r_vcount > CFG_W'(MAX_VERTICES)) begin
            s_n = CFG_W'(MAX_VERTICES);
        end else begin
            s_n = r_vcount;
        end
        for (int i = 0; i < MAX_VERTICES; i++) begin
            s_in_use[i] = (CFG_W'(i) < s_n);
        end
    end

    assign s_last_idx = VIDX_W'(s_n - CFG_W'(1));
    assign s_vtx_last = (r_vtx == s_last_idx);

    // Take rule: not colored, not excluded by a set member's row, and this
    // row names no vertex already in the set (covers one-sided edges)
    assign s_vbit = {{(MAX_VERTICES-1){1'b0}}, 1'b1} << r_vtx;
    assign s_row  = r_adj_rd[MAX_VERTICES-1:0];
    assign s_take = (((r_colored | r_excl) & s_vbit) == '0) && ((s_row & r_sel) == '0);
    assign s_colored_after = r_colored | (s_take ? s_vbit : '0);

    // Input transfer
    assign i_in.ready = i_cmd.in_ready;
    assign s_acc      = i_in.valid && i_in.ready;
    assign s_wr_ok    = (CFG_W'(i_in.vertex_index) < CFG_W'(MAX_VERTICES));

    assign s_out_free = !r_out_valid || o_out.ready;

    // Status to controller
    always_comb begin
        o_status.last_accept = s_acc && i_in.last_row;
        o_status.vtx_last    = s_vtx_last;
        o_status.all_colored = ((s_colored_after & s_in_use) == s_in_use);
        o_status.out_free    = s_out_free;
    end

    // Adjacency memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (s_acc && s_wr_ok) begin
            r_adj_mem[i_in.vertex_index[VIDX_W-1:0]] <= i_in.adjacency_row;
        end
        r_adj_rd <= r_adj_mem[r_vtx];
    end

    // Color memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.eval && s_take) begin
            r_color_mem[r_vtx] <= r_round;
        end
        r_color_rd <= r_color_mem[r_vtx];
    end

    // Scan / emit bookkeeping
    always_comb begin
        n_vtx     = r_vtx;
        n_colored = r_colored;
        n_sel     = r_sel;
        n_excl    = r_excl;
        n_round   = r_round;
        if (i_cmd.start_scan) begin
            n_vtx     = '0;
            n_colored = '0;
            n_sel     = '0;
            n_excl    = '0;
            n_round   = '0;
        end else if (i_cmd.eval) begin
            if (s_take) begin
                n_colored = r_colored | s_vbit;
                n_sel     = r_sel | s_vbit;
                n_excl    = r_excl | s_row;
            end
            if (s_vtx_last) begin
                n_vtx   = '0;
                n_sel   = '0;
                n_excl  = '0;
                n_round = r_round + COLOR_W'(1);
            end else begin
                n_vtx = r_vtx + VIDX_W'(1);
            end
        end else if (i_cmd.emit_load) begin
            n_vtx = s_vtx_last ? '0 : r_vtx + VIDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vtx     <= '0;
            r_colored <= '0;
            r_sel     <= '0;
            r_excl    <= '0;
            r_round   <= '0;
            r_vcount  <= VCOUNT_RESET;
        end else begin
            r_vtx     <= n_vtx;
            r_colored <= n_colored;
            r_sel     <= n_sel;
            r_excl    <= n_excl;
            r_round   <= n_round;
            if (i_cfg_wr_en) begin
                r_vcount <= i_cfg_wr_data;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_load) begin
            r_out_vertex <= IDX_W'(r_vtx);
            r_out_color  <= r_color_rd;
            r_out_last   <= s_vtx_last;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.result_vertex = r_out_vertex;
    assign o_out.vertex_color  = r_out_color;
    assign o_out.last_result   = r_out_last;

endmodule

// ===== hdl/greedy_independent_set_coloring.sv =====
// Greedy graph coloring by maximal independent sets. Adjacency rows load one
// per cycle while the block is loading; the row flagged last_row starts
// coloring of vertices 0..n-1, with n = vertex_count saturated to 1..64. Each
// round walks the vertices in index order (one registered read of the
// adjacency memory, then the take decision); coloring ends after R rounds
// (R <= n). The n results then leave, each after a registered read of the
// color memory, while the output side is ready, the final one with last_result
// set. No input is taken from the last row until the final result has been
// loaded into the output register. Vertices u and v are neighbours when either
// row names the other; self loops and bits at or above n are ignored. Rows of
// vertices below n must have been written before coloring starts.
module greedy_independent_set_coloring (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [gisc_pkg::CFG_W-1:0]   i_cfg_wr_data,
    gisc_in_if.sink                      i_in,
    gisc_out_if.source                   o_out
);
    import gisc_pkg::*;

    t_cmd    s_cmd;
    t_status s_status;

    gisc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (s_status),
        .o_cmd    (s_cmd)
    );

    gisc_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in          (i_in),
        .o_out         (o_out),
        .i_cmd         (s_cmd),
        .o_status      (s_status)
    );

`ifndef SYNTH
    // Coloring starts: no further rows are taken the next cycle
    a_busy_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_status.last_accept |=> !i_in.ready)
        else $error("input ready while coloring");

    // Loading the final result returns the block to row loading
    a_back_to_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_cmd.emit_load && s_status.vtx_last |=> i_in.ready)
        else $error("block did not return to loading");

    // Each round colors the lowest uncolored vertex, so color never exceeds index
    a_color_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.vertex_color <= o_out.result_vertex))
        else $error("color above vertex index");
`endif

endmodule

// ===== bench/gisc_checker.sv =====
`timescale 1ns / 1ps

// Watches the row and color channels, keeps its own copy of the stored graph
// and the vertex count, and scores every color transfer against the prediction.
module gisc_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [gisc_pkg::CFG_W-1:0] i_cfg_wr_data,
    gisc_in_if                         i_rows,
    gisc_out_if                        i_colors,
    output int                         o_mismatch_count,
    output int                         o_results_pending
);
    import gisc_pkg::*;

    typedef struct packed {
        logic [IDX_W-1:0]   vertex;
        logic [COLOR_W-1:0] color;
        logic               last;
    } t_vertex_color;

    logic [ROW_W-1:0] adj_rows [MAX_VERTICES];
    logic [CFG_W-1:0] vertex_count;
    t_vertex_color    expected_colors [$];
    int               mismatches = 0;

    // Greedy coloring by rounds of independent sets over the vertices in use
    function automatic void predict_colors();
        int                 n;
        logic [ROW_W-1:0]   in_use;
        logic [ROW_W-1:0]   colored;
        logic [ROW_W-1:0]   excluded;
        logic [ROW_W-1:0]   nbrs;
        logic [COLOR_W-1:0] round_no;
        logic [COLOR_W-1:0] color_of [MAX_VERTICES];
        t_vertex_color      res;

        n = (vertex_count == '0) ? 1 :
            (int'(vertex_count) > MAX_VERTICES) ? MAX_VERTICES : int'(vertex_count);
        in_use   = {ROW_W{1'b1}} >> (ROW_W - n);
        colored  = '0;
        round_no = '0;
        while ((colored & in_use) != in_use) begin
            excluded = '0;
            for (int v = 0; v < n; v++) begin
                if (!colored[v] && !excluded[v]) begin
                    // an edge counts when either row names the other; no self loops
                    nbrs = adj_rows[v];
                    for (int u = 0; u < n; u++) begin
                        if (adj_rows[u][v]) nbrs[u] = 1'b1;
                    end
                    nbrs        = nbrs & in_use;
                    nbrs[v]     = 1'b0;
                    color_of[v] = round_no;
                    colored[v]  = 1'b1;
                    excluded    = excluded | nbrs;
                end
            end
            round_no = round_no + 1'b1;
        end

        for (int v = 0; v < n; v++) begin
            res.vertex      = IDX_W'(v);
            res.color       = color_of[v];
            res.last        = (v == n - 1);
            expected_colors = {expected_colors, res};
        end
    endfunction

    always @(posedge i_clk) begin
        t_vertex_color exp_res;

        if (!i_rst_n) begin
            vertex_count = VCOUNT_RESET;
            expected_colors.delete();
        end else begin
            if (i_cfg_wr_en) vertex_count = i_cfg_wr_data;

            // color side first: a result transfer always belongs to an older graph
            if (i_colors.valid && i_colors.ready) begin
                if (expected_colors.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result: vertex %0d color %0d last %0b", $time,
                             i_colors.result_vertex, i_colors.vertex_color,
                             i_colors.last_result);
                end else begin
                    exp_res = expected_colors.pop_front();
                    if (i_colors.result_vertex !== exp_res.vertex) begin
                        mismatches++;
                        $display("%0t: result_vertex expected %0d, got %0d", $time,
                                 exp_res.vertex, i_colors.result_vertex);
                    end
                    if (i_colors.vertex_color !== exp_res.color) begin
                        mismatches++;
                        $display("%0t: vertex %0d color expected %0d, got %0d", $time,
                                 exp_res.vertex, exp_res.color, i_colors.vertex_color);
                    end
                    if (i_colors.last_result !== exp_res.last) begin
                        mismatches++;
                        $display("%0t: vertex %0d last_result expected %0b, got %0b", $time,
                                 exp_res.vertex, exp_res.last, i_colors.last_result);
                    end
                end
            end

            // row transfer: store it, and the last row kicks off a coloring
            if (i_rows.valid && i_rows.ready) begin
                adj_rows[i_rows.vertex_index] = i_rows.adjacency_row;
                if (i_rows.last_row) predict_colors();
            end
        end

        o_mismatch_count  <= mismatches;
        o_results_pending <= expected_colors.size();
    end

endmodule

// ===== bench/greedy_independent_set_coloring_tb.sv =====
`timescale 1ns / 1ps

module greedy_independent_set_coloring_tb;
    import gisc_pkg::*;

    typedef enum logic [1:0] {
        ROWS_EMPTY,
        ROWS_FULL,
        ROWS_RANDOM,
        ROWS_SPARSE
    } t_row_mix;

    localparam int RANDOM_ROWS  = 150;
    localparam int LARGE_GRAPHS = 3;

    logic             i_clk;
    logic             i_rst_n;
    logic             cfg_wr_en;
    logic [CFG_W-1:0] cfg_wr_data;

    gisc_in_if  row_bus ();
    gisc_out_if color_bus ();

    int                      mismatch_count;
    int                      results_pending;
    logic [MAX_VERTICES-1:0] rows_loaded;
    int                      rows_sent;
    int                      send_gap_max;
    int                      recv_gap_max;
    int                      long_hold_cycles;
    int                      large_graphs;
    int                      vertices_in_use;

    greedy_independent_set_coloring u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in          (row_bus),
        .o_out         (color_bus)
    );

    gisc_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (cfg_wr_en),
        .i_cfg_wr_data     (cfg_wr_data),
        .i_rows            (row_bus),
        .i_colors          (color_bus),
        .o_mismatch_count  (mismatch_count),
        .o_results_pending (results_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    function automatic logic [ROW_W-1:0] make_row(input t_row_mix mix);
        case (mix)
            ROWS_EMPTY:  return '0;
            ROWS_FULL:   return '1;
            ROWS_RANDOM: return {$urandom, $urandom};
            default:     return {$urandom, $urandom} & {$urandom, $urandom} &
                                {$urandom, $urandom};
        endcase
    endfunction

    // One row transfer; valid stays up when the next row follows without a gap
    task automatic send_row(input logic [IDX_W-1:0] idx, input logic [ROW_W-1:0] row,
                            input logic last);
        int gap;
        gap = $urandom_range(0, send_gap_max);
        if (gap != 0) begin
            row_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        row_bus.valid         <= 1'b1;
        row_bus.vertex_index  <= idx;
        row_bus.adjacency_row <= row;
        row_bus.last_row      <= last;
        do @(posedge i_clk); while (!row_bus.ready);
        rows_loaded[idx] = 1'b1;
        rows_sent++;
    endtask

    task automatic drain_results();
        row_bus.valid <= 1'b0;
        do @(posedge i_clk); while (results_pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_vertex_count(input logic [CFG_W-1:0] value);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
        vertices_in_use = (value == '0) ? 1 :
                          (int'(value) > MAX_VERTICES) ? MAX_VERTICES : int'(value);
    endtask

    // Rows in shuffled order, the final one flagged last. Every vertex in use
    // must hold a row before coloring; loaded rows get rewritten at random.
    task automatic send_graph(input t_row_mix mix, input int rewrite_odds);
        int       order [$];
        int       pick;
        int       tmp;
        t_row_mix row_mix;

        for (int v = 0; v < vertices_in_use; v++) begin
            if (!rows_loaded[v] || $urandom_range(0, rewrite_odds - 1) == 0)
                order = {order, v};
        end
        // rows beyond the vertices in use are stored but play no part
        if (vertices_in_use < MAX_VERTICES) begin
            repeat ($urandom_range(0, 2))
                order = {order, int'($urandom_range(vertices_in_use, MAX_VERTICES - 1))};
        end
        if (order.size() == 0) order = {order, int'($urandom_range(0, MAX_VERTICES - 1))};

        for (int i = order.size() - 1; i > 0; i--) begin
            pick        = $urandom_range(0, i);
            tmp         = order[i];
            order[i]    = order[pick];
            order[pick] = tmp;
        end

        foreach (order[i]) begin
            // odd rows mixed in, except where a full clique is wanted
            row_mix = (mix != ROWS_FULL && $urandom_range(0, 7) == 0) ?
                      t_row_mix'($urandom_range(0, 3)) : mix;
            send_row(IDX_W'(order[i]), make_row(row_mix), i == order.size() - 1);
        end
    endtask

    // Result side: random ready gaps, plus one long hold on request
    initial begin
        int gap;
        color_bus.ready = 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (long_hold_cycles != 0) begin
                color_bus.ready <= 1'b0;
                repeat (long_hold_cycles) @(posedge i_clk);
                long_hold_cycles = 0;
            end else begin
                gap = $urandom_range(0, recv_gap_max);
                if (gap != 0) begin
                    color_bus.ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            color_bus.ready <= 1'b1;
            do @(posedge i_clk); while (!color_bus.valid);
        end
    end

    // Stimulus and verdict
    initial begin
        int               random_start;
        logic [CFG_W-1:0] count_value;
        t_row_mix         mix;

        i_rst_n               = 1'b0;
        cfg_wr_en             = 1'b0;
        cfg_wr_data           = '0;
        row_bus.valid         = 1'b0;
        row_bus.vertex_index  = '0;
        row_bus.adjacency_row = '0;
        row_bus.last_row      = 1'b0;
        rows_loaded           = '0;
        rows_sent             = 0;
        send_gap_max          = 9;
        recv_gap_max          = 9;
        long_hold_cycles      = 0;
        large_graphs          = 0;
        vertices_in_use       = MAX_VERTICES;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // count 0 saturates to one vertex; self loop and far bits ignored
        set_vertex_count('0);
        send_row(IDX_W'(0), '1, 1'b1);

        // one-sided edge: only row 0 names vertex 1; top index stored, unused
        set_vertex_count(CFG_W'(2));
        send_row(IDX_W'(63), '1, 1'b0);
        send_row(IDX_W'(1), '0, 1'b0);
        send_row(IDX_W'(0), 64'h2, 1'b1);

        // path with an isolated vertex and a bit far past the vertices in use
        set_vertex_count(CFG_W'(5));
        send_row(IDX_W'(0), 64'h4 | (64'h1 << 40), 1'b0);
        send_row(IDX_W'(1), '0, 1'b0);
        send_row(IDX_W'(2), 64'h8, 1'b0);
        send_row(IDX_W'(3), '0, 1'b0);
        send_row(IDX_W'(4), 64'h1, 1'b1);

        // triangle
        set_vertex_count(CFG_W'(3));
        send_row(IDX_W'(0), '1, 1'b0);
        send_row(IDX_W'(1), '1, 1'b0);
        send_row(IDX_W'(2), '1, 1'b1);

        // results held back while graphs keep coming: the row side must stall
        drain_results();
        long_hold_cycles = 300;
        send_gap_max     = 0;
        send_row(IDX_W'(1), 64'h5, 1'b0);
        send_row(IDX_W'(0), '0, 1'b1);
        send_row(IDX_W'(2), '0, 1'b1);
        send_row(IDX_W'(0), '1, 1'b1);

        // random graphs, mostly small; a few at the full size
        random_start = rows_sent;
        while (rows_sent - random_start < RANDOM_ROWS) begin
            send_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 9;
            recv_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 9;
            mix          = t_row_mix'($urandom_range(0, 3));
            if (large_graphs < LARGE_GRAPHS &&
                (large_graphs == 0 || $urandom_range(0, 5) == 0)) begin
                // the first one is a full clique and reaches the top color
                case (large_graphs)
                    0: begin
                        count_value = CFG_W'(MAX_VERTICES);
                        mix         = ROWS_FULL;
                    end
                    1:       count_value = '1;
                    default: count_value = CFG_W'($urandom_range(MAX_VERTICES + 1, 126));
                endcase
                large_graphs++;
                set_vertex_count(count_value);
                send_graph(mix, (mix == ROWS_FULL) ? 1 : 4);
            end else begin
                if (vertices_in_use == MAX_VERTICES || $urandom_range(0, 2) == 0)
                    set_vertex_count(CFG_W'($urandom_range(0, 12)));
                send_graph(mix, 2);
            end
        end

        drain_results();
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0 && results_pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/gisc_pkg.sv
hdl/gisc_in_if.sv
hdl/gisc_out_if.sv
hdl/gisc_ctrl.sv
hdl/gisc_datapath.sv
hdl/greedy_independent_set_coloring.sv
bench/gisc_checker.sv
bench/greedy_independent_set_coloring_tb.sv
